@@ src/fvn_pkg.sv @@
// Shared types and constants for the fractal value noise unit.
package fvn_pkg;

  localparam int MAX_OCTAVES_DEF = 8;
  localparam int CURVE_DEPTH_DEF = 256;
  localparam int FRAC_BITS_DEF   = 16;

  localparam int COORD_W    = 32;
  localparam int SEED_W     = 32;
  localparam int COUNT_W    = 4;
  localparam int OCT_W      = 5;
  localparam int PERS_W     = 18;
  localparam int OUT_W      = 24;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;
  localparam int ACC_W      = 48;
  localparam int AMP_W      = 33;
  localparam int SLOT_W     = 4;

  // hash pipeline depth; also the slot index at which the post stage loads
  localparam int HASH_LAT = 4;
  localparam logic [SLOT_W-1:0] SLOT_LAST = 4'd15;
  localparam logic [SLOT_W-1:0] POST_K    = 4'(HASH_LAT);

  localparam logic [31:0] LAT_MUL    = 32'd57;
  localparam logic [31:0] SEED_X_MUL = 32'd7;
  localparam logic [31:0] SEED_Y_MUL = 32'd17;
  localparam logic [31:0] HASH_MUL_A = 32'd60493;
  localparam logic [31:0] HASH_ADD_A = 32'd19990303;
  localparam logic [31:0] HASH_ADD_B = 32'd1376312589;

  localparam logic [AMP_W-1:0] AMP_ONE = 33'd65536;
  localparam logic [AMP_W-1:0] AMP_CAP = 33'h1_0000_0000;

  localparam logic signed [ACC_W-1:0] OUT_MAX = 48'sd8388607;
  localparam logic signed [ACC_W-1:0] OUT_MIN = -48'sd8388608;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SEED_X,
    REG_SEED_Y,
    REG_OCTAVE_COUNT,
    REG_PERSISTENCE
  } cfg_reg_t;

  typedef struct packed {
    logic [31:0]       seed_x7;
    logic [31:0]       seed_y17;
    logic [OCT_W-1:0]  count;
    logic [PERS_W-1:0] pers;
  } fvn_cfg_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
    logic                      valid;
  } fvn_item_t;

  typedef struct packed {
    logic signed [ACC_W-1:0] acc;
    logic [AMP_W-1:0]        amp;
    logic                    valid;
  } fvn_sum_t;

endpackage

@@ src/fvn_hash.sv @@
// Pipelined lattice hash: one node value per cycle while ce is high, four register stages.
module fvn_hash #(
  parameter int FRACTION_BITS = fvn_pkg::FRAC_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            ce,
  input  logic [31:0]                     lat_a,
  input  logic [31:0]                     lat_b,
  output logic signed [FRACTION_BITS+1:0] node_val
);
  import fvn_pkg::*;

  logic [31:0] n1;
  logic [31:0] n_r, n2_r, n3_r, sq_r, t_r, p_r;
  logic [31:0] n_nxt, sq_nxt, t_nxt, p_nxt;
  logic signed [32:0] diff;
  logic signed [32:0] diff_sh;

  assign n1     = lat_a + lat_b * LAT_MUL;
  assign n_nxt  = (n1 << 13) ^ n1;
  assign sq_nxt = n_r * n_r;
  assign t_nxt  = sq_r * HASH_MUL_A + HASH_ADD_A;
  assign p_nxt  = n3_r * t_r + HASH_ADD_B;

  always_ff @(posedge clk) begin
    if (ce) begin
      n_r  <= n_nxt;
      n2_r <= n_r;
      sq_r <= sq_nxt;
      n3_r <= n2_r;
      t_r  <= t_nxt;
      p_r  <= p_nxt;
    end
  end

  assign diff     = 33'sh0_4000_0000 - $signed({2'b00, p_r[30:0]});
  assign diff_sh  = diff >>> (30 - FRACTION_BITS);
  assign node_val = diff_sh[FRACTION_BITS+1:0];

endmodule

@@ src/fvn_cell.sv @@
// One octave cell: hashes a 4x4 lattice patch, then smooths, blends and accumulates.
module fvn_cell #(
  parameter int IDX               = 0,
  parameter int CURVE_TABLE_DEPTH = fvn_pkg::CURVE_DEPTH_DEF,
  parameter int FRACTION_BITS     = fvn_pkg::FRAC_BITS_DEF
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      ce,
  input  logic [fvn_pkg::SLOT_W-1:0] slot_k,
  input  fvn_pkg::fvn_cfg_t         cfg,
  input  fvn_pkg::fvn_item_t        item_in,
  output fvn_pkg::fvn_item_t        item_out,
  input  fvn_pkg::fvn_sum_t         sum_in,
  output fvn_pkg::fvn_sum_t         sum_out
);
  import fvn_pkg::*;

  localparam int F      = FRACTION_BITS;
  localparam int D      = CURVE_TABLE_DEPTH;
  localparam int NODE_W = F + 2;
  localparam int MAG_W  = 33 + IDX;
  localparam int IDXW   = $clog2(D + 1);
  localparam int IPW    = F + 14;

  typedef logic [F:0] curve_t [0:D];

  function automatic curve_t build_curve();
    curve_t c;
    longint x, x2, t, w, j, q;
    logic   low;
    q = longint'(1) <<< 28;
    for (int k = 0; k <= D; k++) begin
      low = (2 * k <= D);
      j   = low ? longint'(k) : longint'(D - k);
      x   = longint'(843314857) * j / CURVE_TABLE_DEPTH;
      x2  = (x * x) >>> 28;
      t   = q;
      t   = q - ((x2 * t) >>> 28) / 182;
      t   = q - ((x2 * t) >>> 28) / 132;
      t   = q - ((x2 * t) >>> 28) / 90;
      t   = q - ((x2 * t) >>> 28) / 56;
      t   = q - ((x2 * t) >>> 28) / 30;
      t   = q - ((x2 * t) >>> 28) / 12;
      t   = q - ((x2 * t) >>> 28) / 2;
      w   = (q - t) / 2;
      w   = (w + (longint'(1) <<< (27 - F))) >>> (28 - F);
      c[k] = low ? (F+1)'(w) : (F+1)'((longint'(1) <<< F) - w);
    end
    return c;
  endfunction

  localparam curve_t CURVE = build_curve();

  function automatic logic [IDXW-1:0] curve_idx(input logic [F-1:0] mag);
    logic [IPW-1:0] p;
    logic [IPW-1:0] s;
    p = IPW'(mag) * IPW'(D) + IPW'(longint'(1) <<< (F - 1));
    s = p >> F;
    if (s > IPW'(D)) s = IPW'(D);
    return s[IDXW-1:0];
  endfunction

  function automatic logic signed [NODE_W-1:0] blend(
    input logic signed [NODE_W-1:0] a,
    input logic signed [NODE_W-1:0] b,
    input logic [F:0]               w
  );
    logic signed [NODE_W:0]       d;
    logic signed [NODE_W+F+2:0]   pr;
    logic signed [NODE_W+F+2:0]   sh;
    logic signed [NODE_W:0]       r;
    d  = {b[NODE_W-1], b} - {a[NODE_W-1], a};
    pr = d * $signed({1'b0, w});
    sh = pr >>> F;
    r  = {a[NODE_W-1], a} + sh[NODE_W:0];
    return r[NODE_W-1:0];
  endfunction

  function automatic logic signed [NODE_W-1:0] smooth(
    input logic signed [NODE_W-1:0] g [16],
    input int cr,
    input int cc
  );
    logic signed [NODE_W+5:0] corners, sides, tot, sh;
    corners = (NODE_W+6)'(g[(cr-1)*4+cc-1]) + (NODE_W+6)'(g[(cr-1)*4+cc+1])
            + (NODE_W+6)'(g[(cr+1)*4+cc-1]) + (NODE_W+6)'(g[(cr+1)*4+cc+1]);
    sides   = (NODE_W+6)'(g[cr*4+cc-1]) + (NODE_W+6)'(g[cr*4+cc+1])
            + (NODE_W+6)'(g[(cr-1)*4+cc]) + (NODE_W+6)'(g[(cr+1)*4+cc]);
    tot     = corners + (sides <<< 1) + ((NODE_W+6)'(g[cr*4+cc]) <<< 2);
    sh      = tot >>> 4;
    return sh[NODE_W-1:0];
  endfunction

  // split of the current point at this octave's scale
  fvn_item_t         item_r;
  logic [32:0]       ax, ay;
  logic [MAG_W-1:0]  mx, my;
  logic [31:0]       ix, iy, ix_mag, iy_mag;
  logic [31:0]       lat_a, lat_b;
  logic signed [NODE_W-1:0] node_val;

  assign ax     = item_r.x[31] ? 33'd0 - {item_r.x[31], item_r.x} : {1'b0, item_r.x};
  assign ay     = item_r.y[31] ? 33'd0 - {item_r.y[31], item_r.y} : {1'b0, item_r.y};
  assign mx     = MAG_W'(ax) << IDX;
  assign my     = MAG_W'(ay) << IDX;
  assign ix_mag = 32'(mx >> F);
  assign iy_mag = 32'(my >> F);
  assign ix     = item_r.x[31] ? 32'd0 - ix_mag : ix_mag;
  assign iy     = item_r.y[31] ? 32'd0 - iy_mag : iy_mag;

  assign lat_a = ix + 32'(slot_k[1:0]) - 32'd1 + cfg.seed_x7;
  assign lat_b = iy + 32'(slot_k[3:2]) - 32'd1 - cfg.seed_y17;

  fvn_hash #(.FRACTION_BITS(F)) u_hash (
    .clk      (clk),
    .ce       (ce),
    .lat_a    (lat_a),
    .lat_b    (lat_b),
    .node_val (node_val)
  );

  // hash stage: hold one item for a slot, hand it on at slot end
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_r.valid <= 1'b0;
    end else if (ce && slot_k == SLOT_LAST) begin
      item_r.valid <= item_in.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (ce && slot_k == SLOT_LAST) begin
      item_r.x <= item_in.x;
      item_r.y <= item_in.y;
    end
  end

  assign item_out = item_r;

  // fraction magnitudes of the item just hashed, held until the post load
  logic [F-1:0] mfx_r, mfy_r;
  logic         mv_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mv_r <= 1'b0;
    end else if (ce && slot_k == SLOT_LAST) begin
      mv_r <= item_r.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (ce && slot_k == SLOT_LAST) begin
      mfx_r <= mx[F-1:0];
      mfy_r <= my[F-1:0];
    end
  end

  // node shift line: entry k ends up holding lattice node k
  logic signed [NODE_W-1:0] sr_r [16];

  always_ff @(posedge clk) begin
    if (ce) begin
      for (int j = 0; j < 15; j++) sr_r[j] <= sr_r[j+1];
      sr_r[15] <= node_val;
    end
  end

  // post stage: inputs hold for a slot, the pipeline below settles well inside it
  logic signed [NODE_W-1:0] g_r [16];
  logic [F-1:0]             pfx_r, pfy_r;
  logic                     pv_r;
  logic signed [ACC_W-1:0]  acc_in_r;
  logic [AMP_W-1:0]         amp_in_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pv_r <= 1'b0;
    end else if (ce && slot_k == POST_K) begin
      pv_r <= mv_r;
    end
  end

  always_ff @(posedge clk) begin
    if (ce && slot_k == POST_K) begin
      g_r      <= sr_r;
      pfx_r    <= mfx_r;
      pfy_r    <= mfy_r;
      acc_in_r <= sum_in.acc;
      amp_in_r <= sum_in.amp;
    end
  end

  logic [F:0] wx, wy;
  assign wx = CURVE[curve_idx(pfx_r)];
  assign wy = CURVE[curve_idx(pfy_r)];

  logic signed [NODE_W-1:0] sm_r [4];
  logic signed [NODE_W-1:0] top_r, bot_r;
  logic signed [NODE_W-1:0] blend_y;
  logic signed [NODE_W:0]   val_r;
  logic signed [NODE_W:0]   val_nxt;
  logic signed [NODE_W+34:0] term_prod;
  logic signed [NODE_W+34:0] term_sh;
  logic signed [ACC_W-1:0]  term_r;
  logic [AMP_W+PERS_W-1:0]  ampm_r;
  logic [AMP_W+PERS_W-1:0]  amp_sh;
  logic [AMP_W-1:0]         amp_new;
  logic signed [ACC_W-1:0]  acc_out_r;
  logic [AMP_W-1:0]         amp_out_r;
  logic                     active;

  assign active    = OCT_W'(IDX) < cfg.count;
  assign blend_y   = blend(top_r, bot_r, wy);
  assign val_nxt   = {blend_y[NODE_W-1], blend_y} + (NODE_W+1)'(longint'(1) <<< (F - 1));
  assign term_prod = val_r * $signed({1'b0, amp_in_r});
  assign term_sh   = term_prod >>> 16;
  assign amp_sh    = ampm_r >> 16;
  assign amp_new   = (amp_sh > (AMP_W+PERS_W)'(AMP_CAP)) ? AMP_CAP : amp_sh[AMP_W-1:0];

  always_ff @(posedge clk) begin
    if (ce) begin
      sm_r[0]   <= smooth(g_r, 1, 1);
      sm_r[1]   <= smooth(g_r, 1, 2);
      sm_r[2]   <= smooth(g_r, 2, 1);
      sm_r[3]   <= smooth(g_r, 2, 2);
      top_r     <= blend(sm_r[0], sm_r[1], wx);
      bot_r     <= blend(sm_r[2], sm_r[3], wx);
      val_r     <= val_nxt;
      term_r    <= term_sh[ACC_W-1:0];
      ampm_r    <= amp_in_r * cfg.pers;
      acc_out_r <= active ? acc_in_r + term_r : acc_in_r;
      amp_out_r <= active ? amp_new : amp_in_r;
    end
  end

  assign sum_out.acc   = acc_out_r;
  assign sum_out.amp   = amp_out_r;
  assign sum_out.valid = pv_r;

endmodule

@@ src/fractal_value_noise_2d_unit.sv @@
// Fractal value noise unit: a chain of one cell per octave.
// Each point runs down a chain of MAX_OCTAVES cells, one per octave. A cell
// spends one slot pushing the sixteen nodes of its 4x4 lattice patch
// through its own pipelined hash unit, then smooths, blends and adds its
// octave during the following slot while hashing the next point. The unit
// takes one point per slot, set by the one-hash-per-cycle rate of each cell
// while the chain is not held. A result waiting at the output only holds
// the chain at the cycle a newer result would replace it.
module fractal_value_noise_2d_unit #(
  parameter int MAX_OCTAVES       = fvn_pkg::MAX_OCTAVES_DEF,
  parameter int CURVE_TABLE_DEPTH = fvn_pkg::CURVE_DEPTH_DEF,
  parameter int FRACTION_BITS     = fvn_pkg::FRAC_BITS_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic signed [fvn_pkg::COORD_W-1:0] in_x_coord,
  input  logic signed [fvn_pkg::COORD_W-1:0] in_y_coord,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic signed [fvn_pkg::OUT_W-1:0]   out_noise_value,
  output logic                               out_saturated,
  input  logic                               cfg_we,
  input  logic [fvn_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [fvn_pkg::CFG_DATA_W-1:0]     cfg_data
);
  import fvn_pkg::*;

  // configuration registers
  logic [SEED_W-1:0]  seed_x_r, seed_y_r;
  logic [COUNT_W-1:0] count_r;
  logic [PERS_W-1:0]  pers_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seed_x_r <= '0;
      seed_y_r <= '0;
      count_r  <= 4'd4;
      pers_r   <= 18'd32768;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        REG_SEED_X:       seed_x_r <= cfg_data[SEED_W-1:0];
        REG_SEED_Y:       seed_y_r <= cfg_data[SEED_W-1:0];
        REG_OCTAVE_COUNT: count_r  <= cfg_data[COUNT_W-1:0];
        REG_PERSISTENCE:  pers_r   <= cfg_data[PERS_W-1:0];
        default:          ;
      endcase
    end
  end

  fvn_cfg_t cfg;
  assign cfg.seed_x7  = seed_x_r * SEED_X_MUL;
  assign cfg.seed_y17 = seed_y_r * SEED_Y_MUL;
  assign cfg.count    = ({1'b0, count_r} > OCT_W'(MAX_OCTAVES)) ? OCT_W'(MAX_OCTAVES)
                                                              : {1'b0, count_r};
  assign cfg.pers     = pers_r;

  // slot counter and chain enable
  logic [SLOT_W-1:0] slot_k_r;
  logic              ce;
  logic              emit;
  fvn_sum_t          sums [MAX_OCTAVES+1];
  fvn_item_t         items [MAX_OCTAVES+1];

  assign ce   = !(slot_k_r == POST_K && sums[MAX_OCTAVES].valid && out_valid && !out_ready);
  assign emit = ce && slot_k_r == POST_K && sums[MAX_OCTAVES].valid;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slot_k_r <= '0;
    end else if (ce) begin
      slot_k_r <= slot_k_r + 4'd1;
    end
  end

  // input holding register, drained into the first cell at slot end
  logic                      hold_v_r, hold_v_nxt;
  logic signed [COORD_W-1:0] hold_x_r, hold_y_r;

  assign in_ready = !hold_v_r;

  always_comb begin
    hold_v_nxt = hold_v_r;
    if (in_valid && in_ready) hold_v_nxt = 1'b1;
    else if (ce && slot_k_r == SLOT_LAST) hold_v_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) hold_v_r <= 1'b0;
    else        hold_v_r <= hold_v_nxt;
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      hold_x_r <= in_x_coord;
      hold_y_r <= in_y_coord;
    end
  end

  assign items[0].x     = hold_x_r;
  assign items[0].y     = hold_y_r;
  assign items[0].valid = hold_v_r;
  assign sums[0].acc    = '0;
  assign sums[0].amp    = AMP_ONE;
  assign sums[0].valid  = 1'b0;

  for (genvar i = 0; i < MAX_OCTAVES; i++) begin : g_cell
    fvn_cell #(
      .IDX               (i),
      .CURVE_TABLE_DEPTH (CURVE_TABLE_DEPTH),
      .FRACTION_BITS     (FRACTION_BITS)
    ) u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .ce       (ce),
      .slot_k   (slot_k_r),
      .cfg      (cfg),
      .item_in  (items[i]),
      .item_out (items[i+1]),
      .sum_in   (sums[i]),
      .sum_out  (sums[i+1])
    );
  end

  // output register with saturation
  logic                    out_valid_r, out_valid_nxt;
  logic signed [OUT_W-1:0] out_val_r;
  logic                    out_sat_r;
  logic signed [ACC_W-1:0] fin;

  assign fin = sums[MAX_OCTAVES].acc;

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (emit)           out_valid_nxt = 1'b1;
    else if (out_ready) out_valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) out_valid_r <= 1'b0;
    else        out_valid_r <= out_valid_nxt;
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      if (fin > OUT_MAX) begin
        out_val_r <= OUT_MAX[OUT_W-1:0];
        out_sat_r <= 1'b1;
      end else if (fin < OUT_MIN) begin
        out_val_r <= OUT_MIN[OUT_W-1:0];
        out_sat_r <= 1'b1;
      end else begin
        out_val_r <= fin[OUT_W-1:0];
        out_sat_r <= 1'b0;
      end
    end
  end

  assign out_valid       = out_valid_r;
  assign out_noise_value = out_val_r;
  assign out_saturated   = out_sat_r;

endmodule

@@ src/fvn_checker.sv @@
// Port-level checks for the fractal value noise unit, bound to the top level.
module fvn_checker (
  input logic                             clk,
  input logic                             rst_n,
  input logic                             in_valid,
  input logic                             in_ready,
  input logic                             out_valid,
  input logic                             out_ready,
  input logic signed [fvn_pkg::OUT_W-1:0] out_noise_value,
  input logic                             out_saturated
);

  // reset empties the result slot and opens the input
  a_reset_out: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("out_valid high after reset");

  a_reset_in: assert property (@(posedge clk) !rst_n |=> in_ready)
    else $error("in_ready low after reset");

  // one transaction fills the input holding register
  a_hold_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input accepted twice in a row");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_noise_value)
                                && $stable(out_saturated))
    else $error("stalled result changed");

endmodule

bind fractal_value_noise_2d_unit fvn_checker u_fvn_checker (.*);
